@@ rtl/core/ars_pkg.sv @@
// constants and types shared by the alu reservation station
`default_nettype none

package ars_pkg;

  // station geometry
  localparam int unsigned SLOTS        = 2;
  localparam int unsigned PIPE_LATENCY = 1;
  localparam int unsigned TAG_BITS     = 5;

  // fixed field widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IN_TAG_W  = 5;
  localparam int unsigned OUT_TAG_W = 5;
  localparam int unsigned OP_W      = 4;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned SHAMT_W   = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_DISPATCH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BROADCAST = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ISSUE     = 2'd2;

  // alu opcodes (octal numbering)
  localparam logic [OP_W-1:0] OP_ADDU = 4'o01;
  localparam logic [OP_W-1:0] OP_SUBU = 4'o03;
  localparam logic [OP_W-1:0] OP_AND  = 4'o04;
  localparam logic [OP_W-1:0] OP_OR   = 4'o05;
  localparam logic [OP_W-1:0] OP_XOR  = 4'o06;
  localparam logic [OP_W-1:0] OP_NOR  = 4'o07;
  localparam logic [OP_W-1:0] OP_SLT  = 4'o12;
  localparam logic [OP_W-1:0] OP_SLTU = 4'o13;
  localparam logic [OP_W-1:0] OP_SLL  = 4'o14;
  localparam logic [OP_W-1:0] OP_SRL  = 4'o16;
  localparam logic [OP_W-1:0] OP_SRA  = 4'o17;

  localparam logic [DATA_W-1:0] TAG_MASK = DATA_W'((1 << TAG_BITS) - 1);

  // payload of one station entry
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [OP_W-1:0]     op;
    logic                a_rdy;
    logic [DATA_W-1:0]   a_data;
    logic                b_rdy;
    logic [DATA_W-1:0]   b_data;
  } slot_t;

  // one stage of the result pipe
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [DATA_W-1:0]   value;
  } pipe_t;

endpackage

`default_nettype wire

@@ rtl/core/alu_reservation_station_core.sv @@
// alu reservation station: entry store, wakeup, oldest-ready issue, alu and result pipe
`default_nettype none

// Usage
//   input channel: a command is transferred on a rising edge with start high and
//   busy low. busy is always low, so a command may be transferred every cycle.
//   in_action selects dispatch, result bus broadcast or issue step; the other
//   in_ fields are read as that action needs them.
//   result channel: every command gives exactly one result transfer. out_valid
//   is high for one cycle, the cycle after the command was taken, and the out_
//   fields are valid with it. The receiver cannot stall; results are not held.
//   Throughput is one command per cycle: the whole action
//   (slot search, wakeup, issue pick, alu, compaction) is one combinational pass
//   between the slot registers and the result registers.
//   out_result_* shows the head of the alu result pipe on an issue step, which
//   lags the issuing entry by PIPE_LATENCY issue steps.
//   Reset (rst_n low, synchronous) empties all slots and the result pipe and
//   drops any pending result strobe; no clearing pass is needed.

module alu_reservation_station_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [ars_pkg::ACT_W-1:0]          in_action,
  input  wire  [ars_pkg::IN_TAG_W-1:0]       in_entry_tag,
  input  wire  [ars_pkg::OP_W-1:0]           in_alu_op,
  input  wire                                in_a_ready,
  input  wire  [ars_pkg::DATA_W-1:0]         in_a_data,
  input  wire                                in_b_ready,
  input  wire  [ars_pkg::DATA_W-1:0]         in_b_data,
  input  wire  [ars_pkg::IN_TAG_W-1:0]       in_bus_tag,
  input  wire  [ars_pkg::DATA_W-1:0]         in_bus_value,
  output logic                               out_valid,
  output logic                               out_result_valid,
  output logic [ars_pkg::OUT_TAG_W-1:0]      out_result_tag,
  output logic [ars_pkg::DATA_W-1:0]         out_result_value,
  output logic                               out_station_full,
  output logic                               out_bad_opcode
);

  localparam int unsigned SLOTS = ars_pkg::SLOTS;
  localparam int unsigned LAT   = ars_pkg::PIPE_LATENCY;

  // slot state: busy bits reset, payload does not
  logic [SLOTS-1:0]       busy_r, busy_nxt;
  ars_pkg::slot_t         slot_r   [SLOTS];
  ars_pkg::slot_t         slot_nxt [SLOTS];

  // result pipe, stage LAT is the tail
  logic [LAT:0]           pipe_v_r, pipe_v_nxt;
  ars_pkg::pipe_t         pipe_r   [LAT+1];
  ars_pkg::pipe_t         pipe_nxt [LAT+1];

  // result registers
  logic                              out_valid_r;
  logic                              res_valid_r, res_valid_nxt;
  logic [ars_pkg::OUT_TAG_W-1:0]     res_tag_r, res_tag_nxt;
  logic [ars_pkg::DATA_W-1:0]        res_value_r, res_value_nxt;
  logic                              full_r, full_nxt;
  logic                              bad_r, bad_nxt;

  // selection vectors
  logic [SLOTS-1:0]       free_pre, free_sel;
  logic [SLOTS-1:0]       rdy_vec, iss_pre, iss_sel, after_iss;
  ars_pkg::slot_t         iss_slot;
  logic                   iss_any;
  logic [ars_pkg::DATA_W:0] alu_out;
  logic                   take;

  assign busy = 1'b0;
  assign take = start && !busy;

  // alu: {supported, result}
  function automatic logic [ars_pkg::DATA_W:0] alu_eval(
    input logic [ars_pkg::OP_W-1:0]   op,
    input logic [ars_pkg::DATA_W-1:0] a,
    input logic [ars_pkg::DATA_W-1:0] b
  );
    logic [ars_pkg::SHAMT_W-1:0] sh;
    logic [ars_pkg::DATA_W:0]    r;
    sh = a[ars_pkg::SHAMT_W-1:0];
    unique case (op)
      ars_pkg::OP_ADDU: r = {1'b1, a + b};
      ars_pkg::OP_SUBU: r = {1'b1, a - b};
      ars_pkg::OP_AND:  r = {1'b1, a & b};
      ars_pkg::OP_OR:   r = {1'b1, a | b};
      ars_pkg::OP_XOR:  r = {1'b1, a ^ b};
      ars_pkg::OP_NOR:  r = {1'b1, ~(a | b)};
      ars_pkg::OP_SLT:  r = {1'b1, ars_pkg::DATA_W'($signed(a) < $signed(b))};
      ars_pkg::OP_SLTU: r = {1'b1, ars_pkg::DATA_W'(a < b)};
      ars_pkg::OP_SLL:  r = {1'b1, b << sh};
      ars_pkg::OP_SRL:  r = {1'b1, b >> sh};
      ars_pkg::OP_SRA:  r = {1'b1, ars_pkg::DATA_W'($signed(b) >>> sh)};
      default:          r = '0;
    endcase
    return r;
  endfunction

  // first free slot and oldest ready slot, one-hot via prefix or
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rdy_vec[i] = busy_r[i] && slot_r[i].a_rdy && slot_r[i].b_rdy;
    end
    free_pre[0] = !busy_r[0];
    iss_pre[0]  = rdy_vec[0];
    for (int i = 1; i < SLOTS; i++) begin
      free_pre[i] = free_pre[i-1] || !busy_r[i];
      iss_pre[i]  = iss_pre[i-1] || rdy_vec[i];
    end
    free_sel[0] = free_pre[0];
    iss_sel[0]  = iss_pre[0];
    for (int i = 1; i < SLOTS; i++) begin
      free_sel[i] = free_pre[i] && !free_pre[i-1];
      iss_sel[i]  = iss_pre[i] && !iss_pre[i-1];
    end
    after_iss = iss_pre;
    iss_any   = iss_pre[SLOTS-1];
  end

  // operand mux for the issuing slot
  always_comb begin
    iss_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (iss_sel[i]) begin
        iss_slot = iss_slot | slot_r[i];
      end
    end
  end

  assign alu_out = alu_eval(iss_slot.op, iss_slot.a_data, iss_slot.b_data);

  // next state for the station and the result pipe
  always_comb begin
    busy_nxt      = busy_r;
    slot_nxt      = slot_r;
    pipe_v_nxt    = pipe_v_r;
    pipe_nxt      = pipe_r;
    res_valid_nxt = 1'b0;
    res_tag_nxt   = '0;
    res_value_nxt = '0;
    bad_nxt       = 1'b0;

    unique case (in_action)
      ars_pkg::ACT_DISPATCH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (free_sel[i]) begin
            busy_nxt[i]        = 1'b1;
            slot_nxt[i].tag    = ars_pkg::TAG_BITS'(in_entry_tag);
            slot_nxt[i].op     = in_alu_op;
            slot_nxt[i].a_rdy  = in_a_ready;
            slot_nxt[i].a_data = in_a_ready ? in_a_data : (in_a_data & ars_pkg::TAG_MASK);
            slot_nxt[i].b_rdy  = in_b_ready;
            slot_nxt[i].b_data = in_b_ready ? in_b_data : (in_b_data & ars_pkg::TAG_MASK);
          end
        end
      end
      ars_pkg::ACT_BROADCAST: begin
        // wakeup of every waiting operand whose producer tag matches
        for (int i = 0; i < SLOTS; i++) begin
          if (busy_r[i] && !slot_r[i].a_rdy &&
              slot_r[i].a_data == ars_pkg::DATA_W'(ars_pkg::TAG_BITS'(in_bus_tag))) begin
            slot_nxt[i].a_rdy  = 1'b1;
            slot_nxt[i].a_data = in_bus_value;
          end
          if (busy_r[i] && !slot_r[i].b_rdy &&
              slot_r[i].b_data == ars_pkg::DATA_W'(ars_pkg::TAG_BITS'(in_bus_tag))) begin
            slot_nxt[i].b_rdy  = 1'b1;
            slot_nxt[i].b_data = in_bus_value;
          end
        end
      end
      ars_pkg::ACT_ISSUE: begin
        // advance the pipe, tail takes the new issue
        for (int i = 0; i < LAT; i++) begin
          pipe_v_nxt[i] = pipe_v_r[i+1];
          pipe_nxt[i]   = pipe_r[i+1];
        end
        pipe_v_nxt[LAT]     = iss_any && alu_out[ars_pkg::DATA_W];
        pipe_nxt[LAT].tag   = (iss_any && alu_out[ars_pkg::DATA_W]) ? iss_slot.tag : '0;
        pipe_nxt[LAT].value = (iss_any && alu_out[ars_pkg::DATA_W]) ?
                              alu_out[ars_pkg::DATA_W-1:0] : '0;
        bad_nxt = iss_any && !alu_out[ars_pkg::DATA_W];
        // close the gap behind the issued slot
        if (iss_any) begin
          for (int k = 0; k < SLOTS - 1; k++) begin
            if (after_iss[k]) begin
              busy_nxt[k] = busy_r[k+1];
              slot_nxt[k] = slot_r[k+1];
            end
          end
          busy_nxt[SLOTS-1] = 1'b0;
        end
        if (pipe_v_nxt[0]) begin
          res_valid_nxt = 1'b1;
          res_tag_nxt   = ars_pkg::OUT_TAG_W'(pipe_nxt[0].tag);
          res_value_nxt = pipe_nxt[0].value;
        end
      end
      default: begin
        // unused action code: no change
      end
    endcase

    full_nxt = busy_nxt[SLOTS-1];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      pipe_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= take;
      if (take) begin
        busy_r   <= busy_nxt;
        pipe_v_r <= pipe_v_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      slot_r      <= slot_nxt;
      pipe_r      <= pipe_nxt;
      res_valid_r <= res_valid_nxt;
      res_tag_r   <= res_tag_nxt;
      res_value_r <= res_value_nxt;
      full_r      <= full_nxt;
      bad_r       <= bad_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_valid = res_valid_r;
  assign out_result_tag   = res_tag_r;
  assign out_result_value = res_value_r;
  assign out_station_full = full_r;
  assign out_bad_opcode   = bad_r;

  // a result strobe only follows a command transfer
  a_strobe_follows_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start))
    else $error("result strobe without a command transfer");

  // busy slots stay packed from slot zero upward
  a_slots_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, busy_r} + (SLOTS+1)'(1)))
    else $error("busy slots not contiguous");

  // opcode error only reported for an issue step
  a_bad_only_on_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_opcode) |-> $past(in_action == ars_pkg::ACT_ISSUE))
    else $error("bad opcode flagged outside an issue step");

  // empty result reads as zero
  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_valid) |-> (out_result_tag == '0 && out_result_value == '0))
    else $error("result fields not zero without a result");

endmodule

`default_nettype wire
